// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, clocked on clk and disabled during reset
`define SOB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sobel_pkg.sv
// package: word types, constants and lane control for the sobel edge unit
package sobel_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 21;
    localparam int ROOT_BITS  = 8;
    localparam int ROOT_IDX_W = $clog2(ROOT_BITS);
    localparam int NUM_LANES  = 3;
    localparam int NUM_TAPS   = 9;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd768;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;
    localparam logic [SUM_W-1:0] MAG_LIMIT = 21'd65280;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_red;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_blue;
    } pix_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_red;
        logic [PIX_W-1:0] edge_green;
        logic [PIX_W-1:0] edge_blue;
        logic             frame_last;
    } edge_word_t;

    typedef struct packed {
        logic                  grad_en;
        logic                  sq_en;
        logic                  root_en;
        logic [ROOT_IDX_W-1:0] root_bit;
    } lane_ctrl_t;

endpackage

// File: design/sobel_edge_magnitude_rgb_unit.sv
// top level: streaming 3x3 sobel edge magnitude on rgb pixels
//
//  channel | handshake                 | word
//  --------+---------------------------+--------------------------------------
//  pixel   | pix_valid / pix_stall     | pix_word  (kind, red, green, blue)
//  edge    | edge_valid / edge_stall   | edge_word (red, green, blue, last)
//  config  | psel / penable / pwrite   | paddr, pwdata, prdata, pready
//
// a word that produces no result goes through accept, then line store and
// window update; a word with a result goes through accept, gradients, squares,
// 8 root steps in each lane, then the load into the output register.
// new words stall until the sequencer is idle; the output register lets a new
// pixel in while a result waits. reset clears counters, window and the output
// valid; line stores are not cleared. a stalled output holds the last step.
module sobel_edge_magnitude_rgb_unit
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_word_t             pix_word,
    output logic                  edge_valid,
    input  logic                  edge_stall,
    output edge_word_t            edge_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "assert_macros.svh"

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int RB  = $clog2(MAX_HEIGHT + 2);
    localparam int OB  = $clog2(MAX_WIDTH * MAX_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAD,
        S_SQ,
        S_ROOT,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [CFG_WIDTH_W-1:0]  width_cfg_reg;
    logic [CFG_HEIGHT_W-1:0] height_cfg_reg;
    logic [WCW-1:0]          w_eff;
    logic [HB-1:0]           h_eff;
    logic [OB-1:0]           wh_m1_reg;
    logic [CB-1:0]           column_count_reg;
    logic [RB-1:0]           row_count_reg;
    logic [OB-1:0]           output_count_reg;
    logic [CB-1:0]           col_reg;
    logic [RGB_W-1:0]        pix_reg;
    logic                    last_reg;
    logic [ROOT_IDX_W-1:0]   bit_reg;
    logic [RGB_W-1:0]        win_reg [6];

    logic                    cfg_wr;
    logic                    pix_acc;
    logic [CB-1:0]           col_now;
    logic [RGB_W-1:0]        upper_rd;
    logic [RGB_W-1:0]        middle_rd;
    logic                    emit;
    logic                    last_now;
    logic                    row_end;
    logic [RB-1:0]           cr;
    logic [CB-1:0]           cc;
    logic                    top_ok;
    logic                    bot_ok;
    logic                    lft_ok;
    logic                    rgt_ok;
    logic [RGB_W-1:0]        tap [NUM_TAPS];
    logic [RGB_W-1:0]        right_col [3];
    logic [NUM_TAPS-1:0][PIX_W-1:0] lane_win [NUM_LANES];
    logic [PIX_W-1:0]        lane_mag [NUM_LANES];
    lane_ctrl_t              lane_ctrl;
    logic                    out_load;
    logic                    out_room;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_FRAME_HEIGHT)
        begin
            prdata = APB_DATA_W'(height_cfg_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(width_cfg_reg);
        end
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = WCW'(1);
        end
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            h_eff = HB'(1);
        end
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HB'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HB'(height_cfg_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        wh_m1_reg <= OB'((WCW + HB)'(w_eff) * (WCW + HB)'(h_eff) - (WCW + HB)'(1));
    end

    // input side
    assign pix_stall = (state_reg != S_IDLE);
    assign pix_acc   = pix_valid && !pix_stall;
    assign col_now   = ((CB + 1)'(column_count_reg) >= (CB + 1)'(w_eff)) ? '0
                                                                         : column_count_reg;

    sobel_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (RGB_W)
    ) u_upper (
        .clk     (clk),
        .wr_en   (state_reg == S_GRAD),
        .wr_addr (col_reg),
        .wr_data (middle_rd),
        .rd_en   (pix_acc),
        .rd_addr (col_now),
        .rd_data (upper_rd)
    );

    sobel_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (RGB_W)
    ) u_middle (
        .clk     (clk),
        .wr_en   (state_reg == S_GRAD),
        .wr_addr (col_reg),
        .wr_data (pix_reg),
        .rd_en   (pix_acc),
        .rd_addr (col_now),
        .rd_data (middle_rd)
    );

    // centre position and frame border
    always_comb
    begin
        emit = (row_count_reg >= RB'(2)) || (row_count_reg == RB'(1) && col_reg != '0);
        if (col_reg != '0)
        begin
            cr = row_count_reg - RB'(1);
            cc = col_reg - CB'(1);
        end
        else
        begin
            cr = row_count_reg - RB'(2);
            cc = CB'(w_eff - WCW'(1));
        end
        top_ok   = (cr != '0);
        bot_ok   = ((RB + 1)'(cr) + (RB + 1)'(1)) < (RB + 1)'(h_eff);
        lft_ok   = (cc != '0);
        rgt_ok   = ((CB + 1)'(cc) + (CB + 1)'(1)) < (CB + 1)'(w_eff);
        last_now = (output_count_reg >= wh_m1_reg);
        row_end  = ((CB + 1)'(col_reg) + (CB + 1)'(1)) >= (CB + 1)'(w_eff);
    end

    always_comb
    begin
        right_col[0] = upper_rd;
        right_col[1] = middle_rd;
        right_col[2] = pix_reg;
        tap[0] = (top_ok && lft_ok) ? win_reg[0] : '0;
        tap[1] = top_ok ? win_reg[3] : '0;
        tap[2] = (top_ok && rgt_ok) ? right_col[0] : '0;
        tap[3] = lft_ok ? win_reg[1] : '0;
        tap[4] = win_reg[4];
        tap[5] = rgt_ok ? right_col[1] : '0;
        tap[6] = (bot_ok && lft_ok) ? win_reg[2] : '0;
        tap[7] = bot_ok ? win_reg[5] : '0;
        tap[8] = (bot_ok && rgt_ok) ? right_col[2] : '0;
    end

    // lanes: red, green, blue
    always_comb
    begin
        lane_ctrl.grad_en  = (state_reg == S_GRAD);
        lane_ctrl.sq_en    = (state_reg == S_SQ);
        lane_ctrl.root_en  = (state_reg == S_ROOT);
        lane_ctrl.root_bit = bit_reg;
    end

    for (genvar ch = 0; ch < NUM_LANES; ch++)
    begin : g_lane
        always_comb
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                lane_win[ch][k] = tap[k][(NUM_LANES - 1 - ch) * PIX_W +: PIX_W];
            end
        end

        sobel_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .win  (lane_win[ch]),
            .mag  (lane_mag[ch])
        );
    end

    assign out_load = (state_reg == S_OUT) && out_room;

    sobel_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .mag_red   (lane_mag[0]),
        .mag_green (lane_mag[1]),
        .mag_blue  (lane_mag[2]),
        .last      (last_reg),
        .stall     (edge_stall),
        .valid     (edge_valid),
        .word      (edge_word),
        .room      (out_room)
    );

    // sequencer, counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            width_cfg_reg    <= FRAME_WIDTH_RESET;
            height_cfg_reg   <= FRAME_HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            output_count_reg <= '0;
            bit_reg          <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_FRAME_WIDTH)
            begin
                width_cfg_reg <= pwdata[CFG_WIDTH_W-1:0];
            end
            else
            begin
                height_cfg_reg <= pwdata[CFG_HEIGHT_W-1:0];
            end
            column_count_reg <= '0;
            row_count_reg    <= '0;
            output_count_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (pix_acc)
                    begin
                        state_reg <= S_GRAD;
                    end
                end
                S_GRAD:
                begin
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= upper_rd;
                    win_reg[4] <= middle_rd;
                    win_reg[5] <= pix_reg;
                    if (emit && last_now)
                    begin
                        column_count_reg <= '0;
                        row_count_reg    <= '0;
                        output_count_reg <= '0;
                    end
                    else
                    begin
                        if (emit)
                        begin
                            output_count_reg <= output_count_reg + OB'(1);
                        end
                        if (row_end)
                        begin
                            column_count_reg <= '0;
                            row_count_reg    <= row_count_reg + RB'(1);
                        end
                        else
                        begin
                            column_count_reg <= col_reg + CB'(1);
                        end
                    end
                    state_reg <= emit ? S_SQ : S_IDLE;
                end
                S_SQ:
                begin
                    bit_reg   <= ROOT_IDX_W'(ROOT_BITS - 1);
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - ROOT_IDX_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_room)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // word payload held for the sequencer
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            col_reg <= col_now;
            pix_reg <= (pix_word.kind == KIND_DRAIN) ? '0
                     : {pix_word.pixel_red, pix_word.pixel_green, pix_word.pixel_blue};
        end
        if (state_reg == S_GRAD)
        begin
            last_reg <= last_now;
        end
    end

    `SOB_ASSERT(a_load_needs_room, out_load |-> out_room, "result loaded into a full output register")
    `SOB_ASSERT(a_col_in_row, (CB + 1)'(column_count_reg) < (CB + 1)'(w_eff), "column count past row width")
    `SOB_ASSERT_NEXT(a_root_done, state_reg == S_ROOT && bit_reg == '0 && !cfg_wr, state_reg == S_OUT, "root steps did not end in output")
    `SOB_ASSERT_NEXT(a_accept_grad, pix_acc && !cfg_wr, state_reg == S_GRAD, "accepted word skipped the gradient step")

endmodule

// File: design/sobel_line_ram.sv
// line store: one write port, one read port with registered read data
module sobel_line_ram
    import sobel_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int WIDTH = RGB_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/sobel_lane.sv
// one color lane: sobel gradients, sum of squares and bit-serial rounded root
module sobel_lane
    import sobel_pkg::*;
(
    input  logic                         clk,
    input  lane_ctrl_t                   ctrl,
    input  logic [NUM_TAPS-1:0][PIX_W-1:0] win,
    output logic [PIX_W-1:0]             mag
);

    logic signed [GRAD_W-1:0]   gx_reg;
    logic signed [GRAD_W-1:0]   gy_reg;
    logic signed [GRAD_W-1:0]   gx_next;
    logic signed [GRAD_W-1:0]   gy_next;
    logic [GRAD_W-2:0]          gx_pos;
    logic [GRAD_W-2:0]          gx_neg;
    logic [GRAD_W-2:0]          gy_pos;
    logic [GRAD_W-2:0]          gy_neg;
    logic signed [2*GRAD_W-1:0] gx_sq;
    logic signed [2*GRAD_W-1:0] gy_sq;
    logic [SUM_W-1:0]           s_reg;
    logic [SUM_W-1:0]           s_next;
    logic [PIX_W-1:0]           n_reg;
    logic [PIX_W-1:0]           n_next;
    logic [PIX_W-1:0]           trial;
    logic [2*PIX_W-1:0]         trial_sq;
    logic [2*PIX_W:0]           upper_bound;

    // taps: index = row * 3 + column
    always_comb
    begin
        gx_pos = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, win[8]};
        gx_neg = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, win[6]};
        gy_pos = {2'b00, win[6]} + {1'b0, win[7], 1'b0} + {2'b00, win[8]};
        gy_neg = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
        gx_next = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy_next = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    always_comb
    begin
        gx_sq  = gx_reg * gx_reg;
        gy_sq  = gy_reg * gy_reg;
        s_next = SUM_W'($unsigned(gx_sq)) + SUM_W'($unsigned(gy_sq));
    end

    // one result bit per step, most significant first
    always_comb
    begin
        trial    = n_reg | (PIX_W'(1) << ctrl.root_bit);
        trial_sq = trial * trial;
        n_next   = (SUM_W'(trial_sq) <= s_reg) ? trial : n_reg;
    end

    always_comb
    begin
        upper_bound = (2*PIX_W+1)'((2*PIX_W)'(n_reg) * (2*PIX_W)'(n_reg))
                    + (2*PIX_W+1)'(n_reg);
        if (s_reg > MAG_LIMIT)
        begin
            mag = MAG_MAX;
        end
        else if (s_reg > SUM_W'(upper_bound))
        begin
            mag = n_reg + PIX_W'(1);
        end
        else
        begin
            mag = n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grad_en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (ctrl.sq_en)
        begin
            s_reg <= s_next;
            n_reg <= '0;
        end
        else if (ctrl.root_en)
        begin
            n_reg <= n_next;
        end
    end

endmodule

// File: design/sobel_merge.sv
// merge stage: gathers the three lane results into the output word register
module sobel_merge
    import sobel_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [PIX_W-1:0] mag_red,
    input  logic [PIX_W-1:0] mag_green,
    input  logic [PIX_W-1:0] mag_blue,
    input  logic             last,
    input  logic             stall,
    output logic             valid,
    output edge_word_t       word,
    output logic             room
);

    logic       valid_reg;
    logic       valid_next;
    edge_word_t word_reg;

    assign room  = !valid_reg || !stall;
    assign valid = valid_reg;
    assign word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.edge_red   <= mag_red;
            word_reg.edge_green <= mag_green;
            word_reg.edge_blue  <= mag_blue;
            word_reg.frame_last <= last;
        end
    end

endmodule
